[design/evpcc_pkg.sv]
// Package with the item types, constants and sample feature function of the pilot controller.
package evpcc_pkg;

    localparam int VW = 29;

    localparam logic [0:0] CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_OC_MARGIN    = 1'b1;

    localparam logic [11:0] PROX_MIN = 12'd1000;
    localparam logic [11:0] PROX_MAX = 12'd4050;
    localparam logic [11:0] PROX_20  = 12'd3210;
    localparam logic [11:0] PROX_32  = 12'd1920;
    localparam logic [11:0] PROX_63  = 12'd1180;

    localparam logic [5:0] AMP_20 = 6'd20;
    localparam logic [5:0] AMP_32 = 6'd32;
    localparam logic [5:0] AMP_63 = 6'd63;

    localparam logic [11:0] CUR_LOW_MAX = 12'd245;
    localparam logic [11:0] CUR_MID_MAX = 12'd2088;
    localparam logic [11:0] CUR_HI_MAX  = 12'd3276;

    localparam logic [9:0] DUTY_IDLE      = 10'd9;
    localparam logic [9:0] DUTY_WAIT      = 10'd49;
    localparam logic [9:0] DUTY_MIN       = 10'd89;
    localparam logic [9:0] DUTY_FAULT     = 10'd979;
    localparam logic [9:0] DUTY_HI_OFFSET = 10'd639;

    localparam logic [VW-1:0] PILOT_GAIN = 29'd76840;
    localparam logic [VW-1:0] V_LIM_1    = 29'd27027;
    localparam logic [VW-1:0] V_LIM_7    = 29'd189189;
    localparam logic [VW-1:0] V_LIM_10   = 29'd270270;

    localparam logic [18:0] AMP_SCALE = 19'd4095;
    localparam logic [18:0] CUR_X100  = 19'd100;

    // Exact reciprocals for floor(s*1000/2457) and floor(s*400/4095) over 12-bit s.
    localparam logic [35:0] MID_RECIP = 36'd6828334;
    localparam logic [34:0] HI_RECIP  = 35'd3277601;

    typedef struct packed {
        logic        button_low;
        logic [11:0] pilot_sample;
        logic [11:0] proximity_sample;
        logic [11:0] current_sample;
    } t_in_item;

    typedef struct packed {
        logic [9:0] pilot_duty;
        logic       charge_relay_on;
        logic       pilot_relay_on;
        logic       fault_led;
    } t_out_item;

    typedef struct packed {
        logic [5:0] idle_timeout_ticks;
        logic [3:0] overcurrent_margin_amps;
    } t_cfg;

    typedef struct packed {
        logic [VW-1:0] pilot_scaled;
        logic          prox_in_band;
        logic [5:0]    amp_rating;
        logic          cur_zero;
        logic          cur_low;
        logic          cur_mid;
        logic          cur_hi;
        logic [18:0]   cur_x100;
        logic [9:0]    duty_mid;
        logic [9:0]    duty_hi;
    } t_prev;

    function automatic t_prev f_prep(input t_in_item item);
        t_prev       pr;
        logic [35:0] mid_prod;
        logic [34:0] hi_prod;
        logic [10:0] q_mid;
        logic [8:0]  q_hi;
        logic [11:0] p;
        logic [11:0] s;
        begin
            p = item.proximity_sample;
            s = item.current_sample;
            pr.pilot_scaled = VW'(item.pilot_sample) * PILOT_GAIN;
            pr.prox_in_band = (p > PROX_MIN) && (p < PROX_MAX);
            if (p > PROX_20) begin
                pr.amp_rating = AMP_20;
            end else if ((p > PROX_32) && (p < PROX_20)) begin
                pr.amp_rating = AMP_32;
            end else if ((p > PROX_63) && (p < PROX_32)) begin
                pr.amp_rating = AMP_63;
            end else begin
                pr.amp_rating = 6'd0;
            end
            pr.cur_zero = (s == 12'd0);
            pr.cur_low  = (s <= CUR_LOW_MAX);
            pr.cur_mid  = (s <= CUR_MID_MAX);
            pr.cur_hi   = (s <= CUR_HI_MAX);
            pr.cur_x100 = 19'(s) * CUR_X100;
            mid_prod = 36'(s) * MID_RECIP;
            hi_prod  = 35'(s) * HI_RECIP;
            q_mid = mid_prod[34:24];
            q_hi  = hi_prod[33:25];
            pr.duty_mid = 10'(q_mid - 11'd1);
            pr.duty_hi  = 10'(q_hi) + DUTY_HI_OFFSET;
            return pr;
        end
    endfunction

endpackage

[design/evpcc_sample_prep.sv]
// Register of the stored samples, kept as the features that the next decision needs.
module evpcc_sample_prep
    import evpcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_in_item i_item,
    output t_prev    o_prev
);

    localparam t_prev PREV_RESET = f_prep(t_in_item'('0));

    t_prev r_prev;
    t_prev n_prev;

    assign n_prev = f_prep(i_item);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= PREV_RESET;
        end else if (i_load) begin
            r_prev <= n_prev;
        end
    end

    assign o_prev = r_prev;

endmodule

[design/evpcc_decide.sv]
// Charging rules: stop, trip and idle state, relay and duty decisions for one item.
module evpcc_decide
    import evpcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic      i_button_low,
    input  t_prev     i_prev,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic       r_stop,    n_stop;
    logic       r_tripped, n_tripped;
    logic [5:0] r_idle,    n_idle;
    logic [9:0] r_duty,    n_duty;
    logic       r_charge,  n_charge;
    logic       r_pilot,   n_pilot;
    logic       r_led,     n_led;

    logic [VW-1:0] duty_inc;
    logic          v_above_1;
    logic          v_below_7;
    logic          v_above_7;
    logic          v_below_10;
    logic [6:0]    amp_limit;
    logic [18:0]   amp_limit_x;
    logic          over_current;
    logic [5:0]    idle_inc;
    logic          stop_req;

    assign duty_inc    = VW'(r_duty) + VW'(1);
    assign v_above_1   = i_prev.pilot_scaled > duty_inc * V_LIM_1;
    assign v_below_7   = i_prev.pilot_scaled < duty_inc * V_LIM_7;
    assign v_above_7   = i_prev.pilot_scaled > duty_inc * V_LIM_7;
    assign v_below_10  = i_prev.pilot_scaled < duty_inc * V_LIM_10;
    assign amp_limit   = 7'(i_prev.amp_rating) + 7'(i_cfg.overcurrent_margin_amps);
    assign amp_limit_x = 19'(amp_limit) * AMP_SCALE;
    assign over_current = i_prev.cur_x100 > amp_limit_x;
    assign idle_inc    = r_idle + 6'd1;
    assign stop_req    = r_stop ^ i_button_low;

    always_comb begin
        n_stop    = stop_req;
        n_tripped = r_tripped;
        n_idle    = r_idle;
        n_duty    = r_duty;
        n_charge  = r_charge;
        n_pilot   = r_pilot;
        n_led     = r_led;
        if (!i_prev.prox_in_band) begin
            n_duty   = DUTY_FAULT;
            n_charge = 1'b0;
            n_pilot  = 1'b0;
            n_led    = 1'b1;
            n_stop   = 1'b0;
        end else if (stop_req) begin
            n_stop    = 1'b0;
            n_tripped = 1'b1;
            n_duty    = DUTY_FAULT;
            n_charge  = 1'b0;
            n_led     = 1'b1;
        end else if (v_above_1 && v_below_7 && !r_tripped) begin
            n_pilot  = 1'b1;
            n_charge = 1'b1;
            n_led    = 1'b0;
            if (i_prev.cur_zero) begin
                n_idle = idle_inc;
                if (idle_inc > i_cfg.idle_timeout_ticks) begin
                    n_idle   = 6'd0;
                    n_duty   = DUTY_IDLE;
                    n_charge = 1'b0;
                    n_led    = 1'b1;
                end
            end else if (i_prev.cur_low) begin
                n_idle = 6'd0;
                n_duty = DUTY_MIN;
            end else if (i_prev.cur_mid) begin
                n_idle = 6'd0;
                n_duty = i_prev.duty_mid;
            end else if (i_prev.cur_hi) begin
                n_idle = 6'd0;
                n_duty = i_prev.duty_hi;
            end else begin
                n_tripped = 1'b1;
                n_stop    = 1'b0;
                n_duty    = DUTY_FAULT;
                n_charge  = 1'b0;
                n_led     = 1'b1;
            end
            if (over_current) begin
                n_idle    = 6'd0;
                n_tripped = 1'b1;
                n_charge  = 1'b0;
                n_led     = 1'b1;
            end
        end else if (r_tripped || (v_above_7 && v_below_10)) begin
            n_tripped = 1'b0;
            n_pilot   = 1'b1;
            n_charge  = 1'b0;
            n_duty    = DUTY_WAIT;
            n_led     = 1'b1;
            n_idle    = idle_inc;
            if (idle_inc > i_cfg.idle_timeout_ticks) begin
                n_idle = 6'd0;
                n_duty = DUTY_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop    <= 1'b0;
            r_tripped <= 1'b0;
            r_idle    <= 6'd0;
            r_duty    <= 10'd0;
            r_charge  <= 1'b0;
            r_pilot   <= 1'b0;
            r_led     <= 1'b0;
        end else if (i_step) begin
            r_stop    <= n_stop;
            r_tripped <= n_tripped;
            r_idle    <= n_idle;
            r_duty    <= n_duty;
            r_charge  <= n_charge;
            r_pilot   <= n_pilot;
            r_led     <= n_led;
        end
    end

    assign o_result.pilot_duty      = n_duty;
    assign o_result.charge_relay_on = n_charge;
    assign o_result.pilot_relay_on  = n_pilot;
    assign o_result.fault_led       = n_led;

endmodule

[design/evse_pilot_charge_controller_unit.sv]
// Top level of the control pilot charge controller: handshake, configuration and result register.
// The block takes one item per clock while the output side is not stalled and returns one result
// item for each: the item waits in the input register, and the decision moves it into the result
// register while updating the charging state. Each decision works on the samples of the item
// before it; the samples of the current item are stored for the next one. The throughput is set
// by the decision step, which reads and writes the charging state in the same step. Configuration
// writes take effect at once and are meant for times when no item is in flight.
module evse_pilot_charge_controller_unit
    import evpcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    logic      advance;
    t_prev     prev;
    t_out_item result;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout_ticks      <= 6'd30;
            r_cfg.overcurrent_margin_amps <= 4'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDLE_TIMEOUT) begin
                r_cfg.idle_timeout_ticks <= i_cfg_data;
            end else if (i_cfg_index == CFG_OC_MARGIN) begin
                r_cfg.overcurrent_margin_amps <= i_cfg_data[3:0];
            end
        end
    end

    evpcc_sample_prep u_sample_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_item  (r_in_item),
        .o_prev  (prev)
    );

    evpcc_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_button_low (r_in_item.button_low),
        .i_prev       (prev),
        .i_cfg        (r_cfg),
        .o_result     (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[design/evpcc_checker.sv]
// Port-level checks of the pilot controller and their binding to the top level.
module evpcc_checker
    import evpcc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("A stalled result item changed or vanished.");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.pilot_duty <= 10'd999)
        else $error("The pilot duty is above the PWM period.");

    a_charge_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.charge_relay_on
            |-> o_out_item.pilot_relay_on && !o_out_item.fault_led)
        else $error("The charge relay is on without the pilot relay or with the fault LED.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("The input stalls while the result register can move.");

endmodule

bind evse_pilot_charge_controller_unit evpcc_checker u_checker (.*);
